// File: design/voltage_calibration_table_lookup_defines.svh
// Assertion macros used by the checker of the calibration table lookup.
`ifndef VOLTAGE_CALIBRATION_TABLE_LOOKUP_DEFINES_SVH
`define VOLTAGE_CALIBRATION_TABLE_LOOKUP_DEFINES_SVH

// Check a consequence in the same cycle as its cause.
`define VCTL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its cause.
`define VCTL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/vctl_pkg.sv
// Shared types, constants and control structs of the calibration table lookup.
package vctl_pkg;

  // Fixed field widths
  localparam int unsigned MV_W   = 16;
  localparam int unsigned TIME_W = 16;
  // Decivolt value of a 16-bit millivolt input fits in 10 bits (max 655)
  localparam int unsigned DV_W   = 10;

  // Default table geometry
  localparam int unsigned MIN_DECIVOLT_DEF = 100;
  localparam int unsigned TABLE_DEPTH_DEF  = 64;

  // Rounding to tenths of a volt: (mv + 50) / 100 as multiply by reciprocal.
  // 83887 / 2^23 is exact for every dividend below 91180, which covers the
  // largest rounded input 65535 + 50.
  localparam logic [MV_W:0] ROUND_OFS   = 17'd50;
  localparam logic [MV_W:0] RECIP_MUL   = 17'd83887;
  localparam int unsigned   RECIP_SHIFT = 23;

  // Command codes
  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  typedef struct packed {
    logic              command;
    logic [MV_W-1:0]   voltage_mv;
    logic [TIME_W-1:0] sample_time_ms;
  } in_t;

  typedef struct packed {
    logic              accepted;
    logic [TIME_W-1:0] expected_time_ms;
  } out_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;
    logic divide;
    logic decode;
    logic scan;
  } ctl_t;

  // Status from datapath to controller
  typedef struct packed {
    logic is_lookup;
    logic found;
  } sts_t;

endpackage

// File: design/vctl_ctrl.sv
// Sequencing state machine of the calibration table lookup.
module vctl_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  vctl_pkg::sts_t sts_i,
  output vctl_pkg::ctl_t ctl_o,
  output logic          busy_o,
  output logic          done_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_DECODE,
    S_SCAN,
    S_RESP
  } state_e;

  state_e state_q, state_d;
  logic   busy_q, busy_d;
  logic   done_q, done_d;

  // Decode commands and next state
  always_comb begin
    state_d = state_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    ctl_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          ctl_o.load = 1'b1;
          busy_d     = 1'b1;
          state_d    = S_DIV;
        end
      end
      S_DIV: begin
        ctl_o.divide = 1'b1;
        state_d      = S_DECODE;
      end
      S_DECODE: begin
        ctl_o.decode = 1'b1;
        if (sts_i.is_lookup) begin
          state_d = S_SCAN;
        end else begin
          state_d = S_RESP;
          done_d  = 1'b1;
        end
      end
      S_SCAN: begin
        ctl_o.scan = 1'b1;
        if (sts_i.found) begin
          state_d = S_RESP;
          done_d  = 1'b1;
        end
      end
      S_RESP: begin
        busy_d  = 1'b0;
        state_d = S_IDLE;
      end
      default: begin
        busy_d  = 1'b0;
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= busy_d;
      done_q  <= done_d;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;

endmodule

// File: design/vctl_datapath.sv
// Datapath of the calibration table lookup: rounding, table memory and outward search.
module vctl_datapath #(
  parameter int unsigned MIN_DECIVOLT = vctl_pkg::MIN_DECIVOLT_DEF,
  parameter int unsigned TABLE_DEPTH  = vctl_pkg::TABLE_DEPTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  vctl_pkg::ctl_t ctl_i,
  input  vctl_pkg::in_t  item_i,
  output vctl_pkg::sts_t sts_o,
  output vctl_pkg::out_t result_o
);

  localparam int unsigned DV_W   = vctl_pkg::DV_W;
  localparam int unsigned MV_W   = vctl_pkg::MV_W;
  localparam int unsigned TIME_W = vctl_pkg::TIME_W;
  localparam int unsigned IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W  = IDX_W + 2;
  localparam logic [DV_W:0] LO_BOUND = (DV_W+1)'(MIN_DECIVOLT);
  localparam logic [DV_W:0] HI_BOUND = (DV_W+1)'(MIN_DECIVOLT + TABLE_DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

  // Item registers
  vctl_pkg::in_t     cmd_q;
  logic [MV_W:0]     x_q;
  logic [DV_W-1:0]   dv_q;
  logic [IDX_W-1:0]  idx_q;
  logic [CNT_W-1:0]  dist_q;
  vctl_pkg::out_t    res_q;

  // Table storage and read registers
  logic [TIME_W-1:0] mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] valid_q;
  logic [TIME_W-1:0] rd_lo_q, rd_hi_q;
  logic              lo_ok_q, hi_ok_q;
  logic              lo_in_q, hi_in_q;

  logic [2*MV_W+1:0] prod;
  logic [DV_W-1:0]   dv_d;
  logic [DV_W:0]     dv_ext, clamped;
  logic              in_range;
  logic [IDX_W-1:0]  idx_d, wr_idx;
  logic              wr_en;
  logic [CNT_W-1:0]  idx_ext;
  logic [IDX_W-1:0]  addr_lo, addr_hi;
  logic              lo_in, hi_in;
  logic [TIME_W-1:0] lo_val, hi_val, pick;
  logic              lo_nz, hi_nz, found;
  logic [TIME_W:0]   pair_sum;

  // Round to decivolts by reciprocal multiply
  assign prod = x_q * vctl_pkg::RECIP_MUL;
  assign dv_d = prod[vctl_pkg::RECIP_SHIFT +: DV_W];

  // Range check and clamp into the table
  assign dv_ext   = {1'b0, dv_q};
  assign in_range = (dv_ext >= LO_BOUND) && (dv_ext <= HI_BOUND);
  always_comb begin
    if (dv_ext < LO_BOUND) begin
      clamped = LO_BOUND;
    end else if (dv_ext > HI_BOUND) begin
      clamped = HI_BOUND;
    end else begin
      clamped = dv_ext;
    end
  end
  assign idx_d  = IDX_W'(clamped - LO_BOUND);
  assign wr_idx = IDX_W'(dv_ext - LO_BOUND);
  assign wr_en  = ctl_i.decode && (cmd_q.command == vctl_pkg::CMD_ADD) && in_range;

  // Select read addresses: exact entry on decode, neighbor pair while scanning
  assign idx_ext = CNT_W'(idx_q);
  always_comb begin
    if (ctl_i.decode) begin
      addr_lo = idx_d;
      addr_hi = idx_d;
      lo_in   = 1'b1;
      hi_in   = 1'b0;
    end else begin
      addr_lo = IDX_W'(idx_ext - dist_q);
      addr_hi = IDX_W'(idx_ext + dist_q);
      lo_in   = dist_q <= idx_ext;
      hi_in   = (idx_ext + dist_q) < DEPTH_C;
    end
  end

  // Write and read the table
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_idx] <= cmd_q.sample_time_ms;
    end
    rd_lo_q <= mem[addr_lo];
    rd_hi_q <= mem[addr_hi];
  end

  // Mark written entries; reset empties the whole table at once
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en) begin
      valid_q[wr_idx] <= 1'b1;
    end
  end

  // Evaluate the pair read in the previous cycle
  assign lo_val   = lo_ok_q ? rd_lo_q : '0;
  assign hi_val   = hi_ok_q ? rd_hi_q : '0;
  assign lo_nz    = lo_val != '0;
  assign hi_nz    = hi_val != '0;
  assign pair_sum = {1'b0, lo_val} + {1'b0, hi_val};
  assign found    = lo_nz || hi_nz || (!lo_in_q && !hi_in_q);
  always_comb begin
    if (lo_nz && hi_nz) begin
      pick = pair_sum[TIME_W:1];
    end else if (lo_nz) begin
      pick = lo_val;
    end else begin
      pick = hi_val;
    end
  end

  // Advance item registers
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cmd_q <= item_i;
      x_q   <= {1'b0, item_i.voltage_mv} + vctl_pkg::ROUND_OFS;
    end
    if (ctl_i.divide) begin
      dv_q <= dv_d;
    end
    if (ctl_i.decode) begin
      idx_q  <= idx_d;
      dist_q <= CNT_W'(1);
    end else if (ctl_i.scan) begin
      dist_q <= dist_q + CNT_W'(1);
    end
    if (ctl_i.decode || ctl_i.scan) begin
      lo_in_q <= lo_in;
      hi_in_q <= hi_in;
      lo_ok_q <= lo_in && valid_q[addr_lo];
      hi_ok_q <= hi_in && valid_q[addr_hi];
    end
    if (ctl_i.decode && (cmd_q.command == vctl_pkg::CMD_ADD)) begin
      res_q.accepted         <= in_range;
      res_q.expected_time_ms <= '0;
    end else if (ctl_i.scan && found) begin
      res_q.accepted         <= 1'b0;
      res_q.expected_time_ms <= pick;
    end
  end

  assign sts_o.is_lookup = cmd_q.command == vctl_pkg::CMD_LOOKUP;
  assign sts_o.found     = found;
  assign result_o        = res_q;

endmodule

// File: design/voltage_calibration_table_lookup.sv
// Top level of the battery voltage calibration table lookup.
// Usage: drive cmd_i and raise start; the command beat is taken at a rising
// edge with start high and busy low. busy stays high until the result beat
// has been shown. An add stores sample_time_ms at the entry for the rounded
// decivolt value if it lies in the table, and accepted tells whether it did;
// a lookup returns the expected time. The result beat sits on result_o for
// exactly one cycle with done_o high; the receiver cannot stall, so it must
// take every beat as it comes. The millivolt value is rounded by a reciprocal
// multiply into a register, then range-checked and clamped. An add shows
// done_o once that check has been made. A lookup then scans outward one
// neighbor pair per cycle through the two read ports of the table memory,
// starting at the exact entry, until it finds a populated entry or both sides
// have left the table, at a distance of at most TABLE_DEPTH. A new command
// may start the cycle after done_o.
// Reset: the per-entry valid flags clear at once, so the table reads empty
// right after reset with no clearing pass; busy and done_o go low.
module voltage_calibration_table_lookup #(
  parameter int unsigned MIN_DECIVOLT = vctl_pkg::MIN_DECIVOLT_DEF,
  parameter int unsigned TABLE_DEPTH  = vctl_pkg::TABLE_DEPTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  vctl_pkg::in_t  cmd_i,
  output logic           done_o,
  output vctl_pkg::out_t result_o
);

  vctl_pkg::ctl_t ctl;
  vctl_pkg::sts_t sts;

  // Sequence the command
  vctl_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .sts_i  (sts),
    .ctl_o  (ctl),
    .busy_o (busy),
    .done_o (done_o)
  );

  // Compute and store
  vctl_datapath #(
    .MIN_DECIVOLT(MIN_DECIVOLT),
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl),
    .item_i  (cmd_i),
    .sts_o   (sts),
    .result_o(result_o)
  );

endmodule

// File: design/vctl_checker.sv
// Port-level checker of the calibration table lookup, bound to the top level.
`include "voltage_calibration_table_lookup_defines.svh"

module vctl_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start_i,
  input logic           busy_i,
  input logic           done_i,
  input vctl_pkg::out_t result_i
);

  // A result beat comes only inside a busy window
  `VCTL_ASSERT_NOW(a_done_in_busy, done_i, busy_i, "result beat outside busy window")

  // A result beat lasts one cycle
  `VCTL_ASSERT_NEXT(a_done_single, done_i, !done_i, "result beat held longer than one cycle")

  // An accepted command raises busy with no result in the next cycle
  `VCTL_ASSERT_NEXT(a_accept_busy, start_i && !busy_i, busy_i && !done_i,
                    "accepted command did not start work")

  // An accepted add carries no time
  `VCTL_ASSERT_NOW(a_add_no_time, done_i && result_i.accepted,
                   result_i.expected_time_ms == 16'd0, "accepted add carries a time")

  // busy drops only right after a result beat
  `VCTL_ASSERT_NOW(a_busy_end, $fell(busy_i), $past(done_i), "busy dropped without result")

endmodule

bind voltage_calibration_table_lookup vctl_checker u_vctl_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start),
  .busy_i  (busy),
  .done_i  (done_o),
  .result_i(result_o)
);
